// ----- rtl/core/cifp_pkg.sv -----
// Shared types, constants and functions of the controller input frame processor.
// Depends on nothing; cifp_stick, cifp_keypad, the top and the testbench import it.
package cifp_pkg;

    localparam int unsigned NUM_PORTS = 2;

    localparam logic [7:0] POT_CENTRE    = 8'd114;
    localparam logic [7:0] POT_MIN_RST   = 8'd6;
    localparam logic [7:0] POT_MAX_RST   = 8'd220;
    localparam logic [8:0] KEY_NONE      = 9'h1FF;
    localparam logic [8:0] KEY_CMP_MASK  = 9'h13F;
    localparam logic [1:0] KEY_MARKS     = 2'b11;
    localparam int unsigned KEY_BIT5     = 5;
    localparam logic [3:0] STICK_CENTRED = 4'hF;
    localparam logic [2:0] SPEED_LAST    = 3'd5;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_MODE  = 3'd0,
        CFG_RAMP_SPEED = 3'd1,
        CFG_POT_MIN    = 3'd2,
        CFG_POT_MAX    = 3'd3,
        CFG_KEY_TOGGLE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic       ramp_mode;
        logic [2:0] ramp_speed;
        logic [7:0] pot_min;
        logic [7:0] pot_max;
        logic       key_toggle;
    } t_cfg;

    typedef struct packed {
        logic [3:0]        stick_a;
        logic [3:0]        stick_b;
        logic              trigger_a;
        logic              trigger_b;
        logic signed [6:0] keypad_code;
        logic              second_button;
        logic              break_irq_enabled;
        logic              key_irq_enabled;
        logic              key_irq_idle;
    } t_request;

    typedef struct packed {
        logic       code_write;
        logic [7:0] code_value;
        logic       break_irq;
        logic       key_irq;
        logic       key_overrun;
        logic [1:0] key_status;
    } t_key_res;

    typedef struct packed {
        logic [7:0] port_bits;
        logic [1:0] trigger_bits;
        logic [7:0] pot_x_a;
        logic [7:0] pot_y_a;
        logic [7:0] pot_x_b;
        logic [7:0] pot_y_b;
        t_key_res   key;
    } t_result;

    function automatic logic [2:0] ramp_step(input logic [2:0] speed, input logic col);
        logic [2:0] row;
        logic [2:0] s;
        row = (speed > SPEED_LAST) ? SPEED_LAST : speed;
        case (row)
            3'd0:    s = 3'd1;
            3'd1:    s = col ? 3'd2 : 3'd1;
            3'd2:    s = 3'd2;
            3'd3:    s = col ? 3'd3 : 3'd2;
            3'd4:    s = 3'd3;
            default: s = col ? 3'd4 : 3'd3;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] pot_move(input logic [7:0] p, input logic neg_n,
                                            input logic pos_n, input t_cfg cfg,
                                            input logic [2:0] step);
        logic [8:0] v;
        logic [7:0] r;
        v = {1'b0, p};
        if (!neg_n) begin
            if (p > cfg.pot_min) begin
                v = {1'b0, p} - {6'd0, step};
                if (v[8]) v = 9'd0;
            end
            r = (v[7:0] <= cfg.pot_min) ? cfg.pot_min : v[7:0];
            if (!cfg.ramp_mode) r = cfg.pot_min;
        end else if (!pos_n) begin
            if (p < cfg.pot_max) begin
                v = {1'b0, p} + {6'd0, step};
                if (v[8]) v = 9'd255;
            end
            r = (v[7:0] >= cfg.pot_max) ? cfg.pot_max : v[7:0];
            if (!cfg.ramp_mode) r = cfg.pot_max;
        end else begin
            r = cfg.ramp_mode ? p : POT_CENTRE;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/cifp_if.sv -----
// Request and result channel interfaces of the controller input frame processor.
// Depends on nothing; payload members carry the field names of each item.
interface cifp_req_if;
    logic              valid;
    logic              ready;
    logic [3:0]        stick_a;
    logic [3:0]        stick_b;
    logic              trigger_a;
    logic              trigger_b;
    logic signed [6:0] keypad_code;
    logic              second_button;
    logic              break_irq_enabled;
    logic              key_irq_enabled;
    logic              key_irq_idle;

    modport source (
        output valid, stick_a, stick_b, trigger_a, trigger_b, keypad_code,
               second_button, break_irq_enabled, key_irq_enabled, key_irq_idle,
        input  ready
    );
    modport sink (
        input  valid, stick_a, stick_b, trigger_a, trigger_b, keypad_code,
               second_button, break_irq_enabled, key_irq_enabled, key_irq_idle,
        output ready
    );
endinterface

interface cifp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] port_bits;
    logic [1:0] trigger_bits;
    logic [7:0] pot_x_a;
    logic [7:0] pot_y_a;
    logic [7:0] pot_x_b;
    logic [7:0] pot_y_b;
    logic       code_write;
    logic [7:0] code_value;
    logic       break_irq;
    logic       key_irq;
    logic       key_overrun;
    logic [1:0] key_status;

    modport source (
        output valid, port_bits, trigger_bits, pot_x_a, pot_y_a, pot_x_b, pot_y_b,
               code_write, code_value, break_irq, key_irq, key_overrun, key_status,
        input  ready
    );
    modport sink (
        input  valid, port_bits, trigger_bits, pot_x_a, pot_y_a, pot_x_b, pot_y_b,
               code_write, code_value, break_irq, key_irq, key_overrun, key_status,
        output ready
    );
endinterface

// ----- rtl/core/cifp_stick.sv -----
// One joystick port: opposite-direction resolution, held-direction memory and
// the two pot axes it drives. Depends on cifp_pkg.
module cifp_stick
    import cifp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic       i_active,
    input  logic [3:0] i_stick,
    input  t_cfg       i_cfg,
    input  logic [2:0] i_step,
    output logic [3:0] o_stick,
    output logic [7:0] o_pot_x,
    output logic [7:0] o_pot_y
);

    logic [3:0] r_held, n_held;
    logic [7:0] r_pot_x;
    logic [7:0] r_pot_y;
    logic [3:0] s;

    always_comb begin
        s      = i_active ? i_stick : STICK_CENTRED;
        n_held = r_held;
        if (s[3:2] == 2'b00) begin
            s[3:2] = r_held[2] ? 2'b10 : 2'b01;
        end else begin
            n_held[3:2] = s[3:2];
        end
        if (s[1:0] == 2'b00) begin
            s[1:0] = r_held[0] ? 2'b10 : 2'b01;
        end else begin
            n_held[1:0] = s[1:0];
        end
        o_stick = s;
        o_pot_x = pot_move(r_pot_x, s[2], s[3], i_cfg, i_step);
        o_pot_y = pot_move(r_pot_y, s[0], s[1], i_cfg, i_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= STICK_CENTRED;
            r_pot_x <= POT_CENTRE;
            r_pot_y <= POT_CENTRE;
        end else if (i_adv) begin
            r_held  <= n_held;
            r_pot_x <= o_pot_x;
            r_pot_y <= o_pot_y;
        end
    end

endmodule

// ----- rtl/core/cifp_keypad.sv -----
// Keypad code latching with bit-5 debounce, second-button marks, break and key
// interrupt requests, overrun and key status. Depends on cifp_pkg.
module cifp_keypad
    import cifp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic signed [6:0] i_code,
    input  logic              i_shift,
    input  logic              i_brk_en,
    input  logic              i_key_en,
    input  logic              i_key_idle,
    input  logic              i_debounce,
    output t_key_res          o_key
);

    logic [8:0] r_prev, n_prev;
    logic       r_brk, r_toggle, n_toggle;
    logic [8:0] kc, kc_m, prev_base;
    logic       kc_pos, held;

    always_comb begin
        kc        = {{2{i_code[6]}}, i_code};
        kc_pos    = !kc[8] && (kc != 9'd0);
        prev_base = kc_pos ? r_prev : KEY_NONE;
        kc_m      = kc;
        if (r_toggle) kc_m[KEY_BIT5] = 1'b0;
        if (i_shift) kc_m[7:6] = KEY_MARKS;
        n_prev   = prev_base;
        n_toggle = r_toggle;
        held     = 1'b0;
        o_key    = '0;
        o_key.break_irq = i_shift && !r_brk && i_brk_en;
        if (kc_pos || i_shift) begin
            n_toggle = i_debounce ? !r_toggle : 1'b0;
            if (!kc_m[8]) begin
                held = 1'b1;
                if (((kc_m ^ prev_base) & KEY_CMP_MASK) != 9'd0) begin
                    n_prev            = kc_m;
                    o_key.code_write  = 1'b1;
                    o_key.code_value  = kc_m[7:0];
                    o_key.key_irq     = i_key_en && i_key_idle;
                    o_key.key_overrun = i_key_en && !i_key_idle;
                end
            end
        end
        o_key.key_status = {i_shift, held};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= KEY_NONE;
            r_brk    <= 1'b0;
            r_toggle <= 1'b0;
        end else if (i_adv) begin
            r_prev   <= n_prev;
            r_brk    <= i_shift;
            r_toggle <= n_toggle;
        end
    end

endmodule

// ----- rtl/core/controller_input_frame_processor.sv -----
// Input register, one logic pass, result register. A request moves on when the result
// register is free or being taken: one request per cycle unless results stall.
// The request side stays ready while the result register is free or being taken.
// Reset (synchronous, active low): config to defaults, pots centred, sticks centred,
// no key held, both registers empty. Depends on cifp_pkg, cifp_if, cifp_stick, cifp_keypad.
module controller_input_frame_processor
    import cifp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cifp_req_if.sink              i_req,
    cifp_res_if.source            o_res
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    t_request   r_req;
    logic       r_out_valid;
    t_result    r_out;
    logic       r_parity;
    logic       w_adv;
    logic [2:0] w_step;
    t_result    w_res;
    t_key_res   w_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_mode  <= 1'b0;
            r_cfg.ramp_speed <= 3'd0;
            r_cfg.pot_min    <= POT_MIN_RST;
            r_cfg.pot_max    <= POT_MAX_RST;
            r_cfg.key_toggle <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RAMP_MODE:  r_cfg.ramp_mode  <= i_cfg_data[0];
                CFG_RAMP_SPEED: r_cfg.ramp_speed <= i_cfg_data[2:0];
                CFG_POT_MIN:    r_cfg.pot_min    <= i_cfg_data[7:0];
                CFG_POT_MAX:    r_cfg.pot_max    <= i_cfg_data[7:0];
                CFG_KEY_TOGGLE: r_cfg.key_toggle <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req.stick_a           <= i_req.stick_a;
            r_req.stick_b           <= i_req.stick_b;
            r_req.trigger_a         <= i_req.trigger_a;
            r_req.trigger_b         <= i_req.trigger_b;
            r_req.keypad_code       <= i_req.keypad_code;
            r_req.second_button     <= i_req.second_button;
            r_req.break_irq_enabled <= i_req.break_irq_enabled;
            r_req.key_irq_enabled   <= i_req.key_irq_enabled;
            r_req.key_irq_idle      <= i_req.key_irq_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (w_adv) begin
            r_parity <= !r_parity;
        end
    end

    assign w_step = ramp_step(r_cfg.ramp_speed, !r_parity);

    cifp_stick u_stick_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_active (NUM_PORTS > 0),
        .i_stick  (r_req.stick_a),
        .i_cfg    (r_cfg),
        .i_step   (w_step),
        .o_stick  (w_res.port_bits[3:0]),
        .o_pot_x  (w_res.pot_x_a),
        .o_pot_y  (w_res.pot_y_a)
    );

    cifp_stick u_stick_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_active (NUM_PORTS > 1),
        .i_stick  (r_req.stick_b),
        .i_cfg    (r_cfg),
        .i_step   (w_step),
        .o_stick  (w_res.port_bits[7:4]),
        .o_pot_x  (w_res.pot_x_b),
        .o_pot_y  (w_res.pot_y_b)
    );

    cifp_keypad u_keypad (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_code     (r_req.keypad_code),
        .i_shift    (r_req.second_button),
        .i_brk_en   (r_req.break_irq_enabled),
        .i_key_en   (r_req.key_irq_enabled),
        .i_key_idle (r_req.key_irq_idle),
        .i_debounce (r_cfg.key_toggle),
        .o_key      (w_key)
    );

    assign w_res.trigger_bits = {(NUM_PORTS > 1) ? r_req.trigger_b : 1'b1,
                                 (NUM_PORTS > 0) ? r_req.trigger_a : 1'b1};
    assign w_res.key          = w_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.port_bits    = r_out.port_bits;
    assign o_res.trigger_bits = r_out.trigger_bits;
    assign o_res.pot_x_a      = r_out.pot_x_a;
    assign o_res.pot_y_a      = r_out.pot_y_a;
    assign o_res.pot_x_b      = r_out.pot_x_b;
    assign o_res.pot_y_b      = r_out.pot_y_b;
    assign o_res.code_write   = r_out.key.code_write;
    assign o_res.code_value   = r_out.key.code_value;
    assign o_res.break_irq    = r_out.key.break_irq;
    assign o_res.key_irq      = r_out.key.key_irq;
    assign o_res.key_overrun  = r_out.key.key_overrun;
    assign o_res.key_status   = r_out.key.key_status;

`ifndef NO_ASSERTIONS
    a_parity_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv) |=> (r_parity != $past(r_parity)))
        else $error("frame parity did not toggle on advance");

    a_write_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.key.code_write) |-> r_out.key.key_status[0])
        else $error("code latched without a held key");

    a_irq_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.key.key_irq && r_out.key.key_overrun))
        else $error("key interrupt and overrun together");

    a_brk_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.key.break_irq) |-> r_out.key.key_status[1])
        else $error("break request without second button");

    a_resolved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.port_bits[1:0] != 2'b00 && r_out.port_bits[3:2] != 2'b00
                      && r_out.port_bits[5:4] != 2'b00 && r_out.port_bits[7:6] != 2'b00))
        else $error("opposite directions left unresolved");
`endif

endmodule

// ----- verif/tb_controller_input_frame_processor.sv -----
// Testbench for controller_input_frame_processor: sends frame requests and checks every
// result against an in-bench model of stick, pot and keypad handling.
// Depends on cifp_pkg, cifp_if and the block's RTL.
`timescale 1ns / 100ps

module tb_controller_input_frame_processor;
    import cifp_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cifp_req_if req();
    cifp_res_if res();

    controller_input_frame_processor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req.sink),
        .o_res      (res.source)
    );

    t_cfg        model_cfg;
    logic        odd_frame;
    logic [8:0]  last_code;
    logic        last_break;
    logic        bit5_clear;
    logic [3:0]  held_dirs [2];
    logic [7:0]  pot_level [4];
    logic [2:0]  ramp_steps [6][2] = '{'{3'd1, 3'd1}, '{3'd1, 3'd2}, '{3'd2, 3'd2},
                                       '{3'd2, 3'd3}, '{3'd3, 3'd3}, '{3'd3, 3'd4}};

    t_result     pending_frames [$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    logic [3:0]        cur_stick_a = 4'hF;
    logic [3:0]        cur_stick_b = 4'hF;
    logic signed [6:0] cur_code    = '0;
    logic              cur_shift   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_request make_frame(input logic [3:0] a, input logic [3:0] b,
                                            input logic ta, input logic tb,
                                            input logic signed [6:0] code, input logic sb,
                                            input logic be, input logic ke, input logic ki);
        t_request r;
        r.stick_a           = a;
        r.stick_b           = b;
        r.trigger_a         = ta;
        r.trigger_b         = tb;
        r.keypad_code       = code;
        r.second_button     = sb;
        r.break_irq_enabled = be;
        r.key_irq_enabled   = ke;
        r.key_irq_idle      = ki;
        return r;
    endfunction

    function automatic logic [7:0] next_pot(input logic [7:0] p, input logic neg_n,
                                            input logic pos_n, input logic [2:0] step);
        int v, lo, hi, st;
        v  = p;
        lo = model_cfg.pot_min;
        hi = model_cfg.pot_max;
        st = step;
        if (!neg_n) begin
            if (!model_cfg.ramp_mode) return model_cfg.pot_min;
            if (v > lo) v = (v - st < 0) ? 0 : v - st;
            return (v <= lo) ? model_cfg.pot_min : v[7:0];
        end
        if (!pos_n) begin
            if (!model_cfg.ramp_mode) return model_cfg.pot_max;
            if (v < hi) v = (v + st > 255) ? 255 : v + st;
            return (v >= hi) ? model_cfg.pot_max : v[7:0];
        end
        return model_cfg.ramp_mode ? p : POT_CENTRE;
    endfunction

    task automatic predict_frame(input t_request r, output t_result e);
        logic [8:0] kc;
        logic [3:0] s;
        logic [3:0] h;
        logic [3:0] sticks [2];
        logic [2:0] step;
        logic       key_pos;
        int         row;
        e = '0;
        odd_frame = ~odd_frame;
        e.key.break_irq = r.second_button && !last_break && r.break_irq_enabled;
        last_break = r.second_button;

        kc = {{2{r.keypad_code[6]}}, r.keypad_code};
        key_pos = !kc[8] && (kc != 9'd0);
        if (!key_pos) last_code = KEY_NONE;
        if (key_pos || r.second_button) begin
            if (bit5_clear) kc[KEY_BIT5] = 1'b0;
            bit5_clear = model_cfg.key_toggle ? ~bit5_clear : 1'b0;
            if (r.second_button) kc[7:6] = KEY_MARKS;
            if (!kc[8]) begin
                e.key.key_status[0] = 1'b1;
                if (((kc ^ last_code) & KEY_CMP_MASK) != 9'd0) begin
                    last_code = kc;
                    e.key.code_write = 1'b1;
                    e.key.code_value = kc[7:0];
                    if (r.key_irq_enabled) begin
                        if (r.key_irq_idle) e.key.key_irq = 1'b1;
                        else e.key.key_overrun = 1'b1;
                    end
                end
            end
        end
        e.key.key_status[1] = r.second_button;

        row  = int'((model_cfg.ramp_speed > SPEED_LAST) ? SPEED_LAST : model_cfg.ramp_speed);
        step = ramp_steps[row][odd_frame];
        for (int i = 0; i < 2; i++) begin
            s = (i == 0) ? r.stick_a : r.stick_b;
            h = held_dirs[i];
            if (s[3:2] == 2'b00) s[3:2] = h[2] ? 2'b10 : 2'b01;
            else h[3:2] = s[3:2];
            if (s[1:0] == 2'b00) s[1:0] = h[0] ? 2'b10 : 2'b01;
            else h[1:0] = s[1:0];
            held_dirs[i] = h;
            sticks[i] = s;
            pot_level[2*i]   = next_pot(pot_level[2*i], s[2], s[3], step);
            pot_level[2*i+1] = next_pot(pot_level[2*i+1], s[0], s[1], step);
        end
        e.port_bits    = {sticks[1], sticks[0]};
        e.trigger_bits = {r.trigger_b, r.trigger_a};
        e.pot_x_a      = pot_level[0];
        e.pot_y_a      = pot_level[1];
        e.pot_x_b      = pot_level[2];
        e.pot_y_b      = pot_level[3];
    endtask

    task automatic drive_payload(input t_request r);
        req.stick_a           = r.stick_a;
        req.stick_b           = r.stick_b;
        req.trigger_a         = r.trigger_a;
        req.trigger_b         = r.trigger_b;
        req.keypad_code       = r.keypad_code;
        req.second_button     = r.second_button;
        req.break_irq_enabled = r.break_irq_enabled;
        req.key_irq_enabled   = r.key_irq_enabled;
        req.key_irq_idle      = r.key_irq_idle;
    endtask

    task automatic send_frame(input t_request r);
        t_result e;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req.valid = 1'b0;
        end
        @(negedge i_clk);
        drive_payload(r);
        req.valid = 1'b1;
        do @(posedge i_clk); while (req.ready !== 1'b1);
        predict_frame(r, e);
        pending_frames.push_back(e);
    endtask

    task automatic settle_block();
        @(negedge i_clk);
        req.valid = 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            CFG_RAMP_MODE:  model_cfg.ramp_mode  = data[0];
            CFG_RAMP_SPEED: model_cfg.ramp_speed = data[2:0];
            CFG_POT_MIN:    model_cfg.pot_min    = data;
            CFG_POT_MAX:    model_cfg.pot_max    = data;
            CFG_KEY_TOGGLE: model_cfg.key_toggle = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_config(input logic analog, input logic [2:0] speed,
                              input logic [7:0] lo, input logic [7:0] hi, input logic deb);
        settle_block();
        write_reg(CFG_RAMP_MODE, {7'($urandom), analog});
        write_reg(CFG_RAMP_SPEED, {5'($urandom), speed});
        write_reg(CFG_POT_MIN, lo);
        write_reg(CFG_POT_MAX, hi);
        write_reg(CFG_KEY_TOGGLE, {7'($urandom), deb});
    endtask

    task automatic next_random_frame(output t_request r);
        int sel;
        if ($urandom_range(99) < 25) cur_stick_a = 4'($urandom);
        if ($urandom_range(99) < 25) cur_stick_b = 4'($urandom);
        if ($urandom_range(99) < 30) begin
            sel = $urandom_range(9);
            if (sel < 4)       cur_code = '0;
            else if (sel == 4) cur_code = -7'sd1;
            else if (sel < 9)  cur_code = 7'($urandom_range(63, 1));
            else               cur_code = 7'($urandom);
        end
        if ($urandom_range(99) < 20) cur_shift = ~cur_shift;
        r = make_frame(cur_stick_a, cur_stick_b, 1'($urandom), 1'($urandom), cur_code,
                       cur_shift, 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (pending_frames.size() == 0) begin
            $display("%0t: result with no request pending, port_bits %0h",
                     $time, res.port_bits);
            mismatch_count++;
        end else begin
            want = pending_frames.pop_front();
            check_field("port_bits", want.port_bits, res.port_bits);
            check_field("trigger_bits", 8'(want.trigger_bits), 8'(res.trigger_bits));
            check_field("pot_x_a", want.pot_x_a, res.pot_x_a);
            check_field("pot_y_a", want.pot_y_a, res.pot_y_a);
            check_field("pot_x_b", want.pot_x_b, res.pot_x_b);
            check_field("pot_y_b", want.pot_y_b, res.pot_y_b);
            check_field("code_write", 8'(want.key.code_write), 8'(res.code_write));
            check_field("code_value", want.key.code_value, res.code_value);
            check_field("break_irq", 8'(want.key.break_irq), 8'(res.break_irq));
            check_field("key_irq", 8'(want.key.key_irq), 8'(res.key_irq));
            check_field("key_overrun", 8'(want.key.key_overrun), 8'(res.key_overrun));
            check_field("key_status", 8'(want.key.key_status), 8'(res.key_status));
        end
    endtask

    initial begin
        res.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res.valid === 1'b1 && res.ready === 1'b1) check_result();
            @(negedge i_clk);
            res.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_frame(make_frame(4'hF, 4'hF, 0, 0, 0, 0, 0, 0, 0));
        send_frame(make_frame(4'h0, 4'h0, 1, 1, 63, 0, 1, 1, 1));
        send_frame(make_frame(4'b0011, 4'b1100, 1, 0, 63, 0, 1, 1, 1));
        send_frame(make_frame(4'b1010, 4'b0101, 0, 1, -1, 1, 1, 1, 1));
        send_frame(make_frame(4'h0, 4'h0, 0, 0, 0, 1, 1, 1, 0));
        send_frame(make_frame(4'b1100, 4'b0011, 1, 1, 37, 1, 1, 1, 1));
        send_frame(make_frame(4'hF, 4'hF, 0, 0, 37, 0, 0, 1, 1));
        send_frame(make_frame(4'b0110, 4'b1001, 1, 1, -64, 0, 1, 0, 0));
        send_frame(make_frame(4'h0, 4'hF, 0, 1, 1, 0, 0, 1, 1));
        send_frame(make_frame(4'hF, 4'h0, 1, 0, 0, 0, 1, 0, 1));
        send_frame(make_frame(4'b0111, 4'b1011, 0, 0, 32, 1, 1, 1, 1));
        send_frame(make_frame(4'b1101, 4'b1110, 1, 1, 63, 0, 0, 0, 0));
        send_frame(make_frame(4'h5, 4'hA, 1, 0, 63, 0, 1, 1, 0));
        send_frame(make_frame(4'hA, 4'h5, 0, 1, -33, 1, 1, 1, 1));
        send_frame(make_frame(4'h0, 4'h0, 1, 1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_pot_ramp();
        logic       analog [8] = '{0, 1, 1, 1, 0, 1, 1, 1};
        logic [2:0] speed  [8] = '{3, 5, 4, 2, 1, 0, 6, 7};
        logic [7:0] lo     [8] = '{2, 0, 6, 255, 100, 100, 30, 0};
        logic [7:0] hi     [8] = '{254, 255, 220, 0, 100, 150, 200, 0};
        t_request   r;
        send_idle_pct  = 55;
        recv_stall_pct = 0;
        for (int k = 0; k < 8; k++) begin
            set_config(analog[k], speed[k], lo[k], hi[k], 1'b0);
            for (int n = 0; n < 40; n++) begin
                if (n < 10 || n >= 30)
                    r = make_frame(4'b0101, 4'b1010, 1, 0, 0, 0, 0, 0, 0);
                else if (n < 24)
                    r = make_frame(4'b1010, 4'b0101, 0, 1, 0, 0, 0, 0, 0);
                else if (n < 27)
                    r = make_frame(4'h0, 4'h0, 1, 1, 0, 0, 0, 0, 0);
                else
                    next_random_frame(r);
                send_frame(r);
            end
        end
    endtask

    task automatic test_debounce();
        logic signed [6:0] code;
        logic              shift;
        int                hold;
        send_idle_pct  = 0;
        recv_stall_pct = 55;
        set_config(1'b1, 3'd3, 8'd6, 8'd220, 1'b1);
        for (int run = 0; run < 12; run++) begin
            code  = 7'($urandom_range(63, 1) | (($urandom_range(1) != 0) ? 32'h20 : 32'h0));
            shift = ($urandom_range(99) < 25);
            hold  = $urandom_range(5, 2);
            for (int n = 0; n < hold; n++)
                send_frame(make_frame(4'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
                                      code, shift, 1'($urandom), 1'($urandom),
                                      1'($urandom)));
            send_frame(make_frame(4'hF, 4'hF, 0, 0, 0, 0, 1, 1, 1));
        end
    endtask

    task automatic test_random();
        int       send_pct  [4] = '{0, 55, 0, 29};
        int       stall_pct [4] = '{0, 0, 55, 29};
        t_request r;
        for (int p = 0; p < 4; p++) begin
            if (p == 3)
                set_config(1'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                           1'($urandom));
            else
                set_config(1'($urandom), 3'($urandom), 8'($urandom_range(120)),
                           8'($urandom_range(255, 130)), 1'($urandom));
            send_idle_pct  = send_pct[p];
            recv_stall_pct = stall_pct[p];
            for (int n = 0; n < 90; n++) begin
                if (p == 1 && n == 45) settle_block();
                next_random_frame(r);
                send_frame(r);
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_RAMP_MODE;
        i_cfg_data = '0;
        req.valid  = 1'b0;
        drive_payload('0);
        model_cfg  = '{ramp_mode: 1'b0, ramp_speed: 3'd0, pot_min: POT_MIN_RST,
                       pot_max: POT_MAX_RST, key_toggle: 1'b0};
        odd_frame  = 1'b0;
        last_code  = KEY_NONE;
        last_break = 1'b0;
        bit5_clear = 1'b0;
        held_dirs  = '{STICK_CENTRED, STICK_CENTRED};
        pot_level  = '{POT_CENTRE, POT_CENTRE, POT_CENTRE, POT_CENTRE};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_pot_ramp();
        test_debounce();
        test_random();

        settle_block();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/cifp_pkg.sv
rtl/core/cifp_if.sv
rtl/core/cifp_stick.sv
rtl/core/cifp_keypad.sv
rtl/core/controller_input_frame_processor.sv
verif/tb_controller_input_frame_processor.sv
